[hdl/iee_pkg.sv]
// iee_pkg: shared types and constants for the infix expression evaluator
// used by iee_ctrl, iee_datapath and infix_expression_evaluator_core
package iee_pkg;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_SUB    = 3'd1;
    localparam logic [2:0] OP_MUL    = 3'd2;
    localparam logic [2:0] OP_DIV    = 3'd3;
    localparam logic [2:0] OP_LPAREN = 3'd4;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_DIV0      = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
    localparam logic [1:0] ERR_MALFORMED = 2'd3;

    localparam logic [7:0] CH_ADD    = 8'h2b;
    localparam logic [7:0] CH_SUB    = 8'h2d;
    localparam logic [7:0] CH_MUL    = 8'h2a;
    localparam logic [7:0] CH_DIV    = 8'h2f;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;

    // controller to datapath commands
    typedef struct packed {
        logic       push_val;    // push digit value
        logic       push_op;     // push operator code
        logic [2:0] op_code;
        logic [3:0] digit;
        logic       pop_op;      // drop top operator
        logic       rd_req;      // fetch top two values
        logic       alu_start;   // start operation on fetched operands
        logic       alu_commit;  // write result, pop one value and one operator
        logic       clear;       // empty both stacks
    } iee_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic       val_full;
        logic       op_full;
        logic       op_empty;
        logic       val_lt2;
        logic       val_one;
        logic [2:0] top_op;      // valid when op not empty
        logic       alu_done;
        logic       div_zero;
    } iee_stat_t;

endpackage

[hdl/infix_expression_evaluator_core.sv]
// Evaluates an infix expression of single digits, + - * / and brackets, one
// character per input item; the item with tlast set yields one result item.
// A digit or '(' is pushed and settled; an ordinary operator is checked against
// the operator stack; each reduction goes through the stack read and ALU, and a
// division via the divider, one quotient bit per cycle. Results wait in S_OUT.
// depends on iee_pkg, iee_ctrl, iee_datapath
module infix_expression_evaluator_core #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // value[31:0], error_code[33:32], zero fill
);
    iee_pkg::iee_cmd_t  cmd;
    iee_pkg::iee_stat_t stat;
    logic [31:0] result;
    logic [1:0]  err;
    logic        sel_val;

    iee_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .char_code(s_tdata), .is_last(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_err(err), .m_sel_val(sel_val),
        .cmd(cmd), .stat(stat)
    );

    iee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .stat(stat), .result(result)
    );

    assign m_tdata = {6'd0, err,
                      (sel_val && err == iee_pkg::ERR_NONE) ? result : 32'd0};

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33:32] != iee_pkg::ERR_NONE) |-> m_tdata[31:0] == 32'd0)
        else $error("error result carries a value");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
`endif
endmodule

[hdl/iee_divider.sv]
// iee_divider: 32-bit signed divider, one quotient bit per cycle, truncating
// depends on nothing but the clock and reset
module iee_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            dvs_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // restoring step on the shifted partial remainder
            if (!trial[32]) begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;
endmodule

[hdl/iee_datapath.sv]
// iee_datapath: value and operator stacks, multiplier and divider
// depends on iee_pkg and iee_divider
module iee_datapath #(
    parameter int STACK_DEPTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  iee_pkg::iee_cmd_t  cmd,
    output iee_pkg::iee_stat_t stat,
    output logic [31:0]        result
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    logic [31:0] val_mem [STACK_DEPTH];
    logic [2:0]  op_mem  [STACK_DEPTH];
    logic [CW-1:0] vcnt_reg, vcnt_next;
    logic [CW-1:0] ocnt_reg, ocnt_next;
    logic [31:0] a_reg, b_reg, top_a, top_b;
    logic [2:0]  top_op_reg;
    logic [31:0] res_reg, res_next;
    logic        alu_busy_reg, alu_done_reg;
    logic        op_div_reg;
    logic        div_done;
    logic [31:0] div_q;
    logic [63:0] prod;

    // top-of-stack registers hold registered reads of the two top values and top operator
    always_ff @(posedge aclk) begin
        if (cmd.push_val && vcnt_reg != DEPTH_C)
            val_mem[vcnt_reg[AW-1:0]] <= {28'd0, cmd.digit};
        else if (cmd.alu_commit)
            val_mem[AW'(vcnt_reg - CW'(2))] <= res_reg;
        if (cmd.push_op && ocnt_reg != DEPTH_C)
            op_mem[ocnt_reg[AW-1:0]] <= cmd.op_code;
        top_a <= val_mem[AW'(vcnt_reg - CW'(2))];
        top_b <= val_mem[AW'(vcnt_reg - CW'(1))];
        top_op_reg <= op_mem[AW'(ocnt_reg - CW'(1))];
    end

    always_comb begin
        vcnt_next = vcnt_reg;
        ocnt_next = ocnt_reg;
        if (cmd.clear) begin
            vcnt_next = '0;
            ocnt_next = '0;
        end else begin
            if (cmd.push_val) vcnt_next = vcnt_reg + CW'(1);
            if (cmd.push_op)  ocnt_next = ocnt_reg + CW'(1);
            if (cmd.pop_op)   ocnt_next = ocnt_reg - CW'(1);
            if (cmd.alu_commit) begin
                vcnt_next = vcnt_reg - CW'(1);
                ocnt_next = ocnt_reg - CW'(1);
            end
        end
    end

    assign prod = a_reg * b_reg;

    always_comb begin
        case (top_op_reg)
            iee_pkg::OP_ADD: res_next = a_reg + b_reg;
            iee_pkg::OP_SUB: res_next = a_reg - b_reg;
            iee_pkg::OP_MUL: res_next = prod[31:0];
            default:         res_next = div_q;
        endcase
    end

    iee_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.alu_start && top_op_reg == iee_pkg::OP_DIV && b_reg != 32'd0),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcnt_reg     <= '0;
            ocnt_reg     <= '0;
            alu_busy_reg <= 1'b0;
            alu_done_reg <= 1'b0;
            op_div_reg   <= 1'b0;
        end else begin
            vcnt_reg     <= vcnt_next;
            ocnt_reg     <= ocnt_next;
            alu_done_reg <= 1'b0;
            if (cmd.alu_start) begin
                op_div_reg   <= (top_op_reg == iee_pkg::OP_DIV) && b_reg != 32'd0;
                alu_busy_reg <= 1'b1;
            end else if (alu_busy_reg && (!op_div_reg || div_done)) begin
                alu_busy_reg <= 1'b0;
                alu_done_reg <= 1'b1;
            end
        end
        if (cmd.rd_req) begin
            a_reg <= top_a;
            b_reg <= top_b;
        end
        if (alu_busy_reg && (!op_div_reg || div_done)) res_reg <= res_next;
    end

    // rd_req comes from S_FETCH, after S_SETTLE and S_CHECK, once the top registers have settled
    assign stat.val_full = (vcnt_reg == DEPTH_C);
    assign stat.op_full  = (ocnt_reg == DEPTH_C);
    assign stat.op_empty = (ocnt_reg == '0);
    assign stat.val_lt2  = (vcnt_reg < CW'(2));
    assign stat.val_one  = (vcnt_reg == CW'(1));
    assign stat.top_op   = top_op_reg;
    assign stat.alu_done = alu_done_reg;
    assign stat.div_zero = (b_reg == 32'd0);
    assign result        = top_b;
endmodule

[hdl/iee_ctrl.sv]
// iee_ctrl: sequencer that decodes characters and drives stack reductions
// depends on iee_pkg
module iee_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         char_code,
    input  logic               is_last,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [1:0]         m_err,
    output logic               m_sel_val,
    output iee_pkg::iee_cmd_t  cmd,
    input  iee_pkg::iee_stat_t stat
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SETTLE = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_FETCH  = 4'd3;
    localparam logic [3:0] S_START  = 4'd4;
    localparam logic [3:0] S_WAIT   = 4'd5;
    localparam logic [3:0] S_COMMIT = 4'd6;
    localparam logic [3:0] S_FINAL  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;
    localparam logic [3:0] S_SETTLE2 = 4'd9;

    // mode of the reduce loop
    localparam logic [1:0] M_OPER  = 2'd0;
    localparam logic [1:0] M_CLOSE = 2'd1;
    localparam logic [1:0] M_DRAIN = 2'd2;

    logic [3:0] state_reg, state_next;
    logic [1:0] err_reg, err_next;
    logic [1:0] mode_reg, mode_next;
    logic [2:0] op_reg, op_next;
    logic       last_reg, last_next;
    logic       sel_reg, sel_next;
    logic       hi_prec, top_hi;

    assign hi_prec = (op_reg == iee_pkg::OP_MUL) || (op_reg == iee_pkg::OP_DIV);
    assign top_hi  = (stat.top_op == iee_pkg::OP_MUL) || (stat.top_op == iee_pkg::OP_DIV);

    always_comb begin
        state_next = state_reg;
        err_next   = err_reg;
        mode_next  = mode_reg;
        op_next    = op_reg;
        last_next  = last_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.op_code = op_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    last_next = is_last;
                    state_next = last_next ? S_SETTLE : S_IDLE;
                    if (err_reg == iee_pkg::ERR_NONE) begin
                        state_next = S_SETTLE;
                        if (char_code >= iee_pkg::CH_ZERO && char_code <= iee_pkg::CH_NINE) begin
                            if (stat.val_full) err_next = iee_pkg::ERR_OVERFLOW;
                            else begin
                                cmd.push_val = 1'b1;
                                cmd.digit = 4'(char_code - iee_pkg::CH_ZERO);
                            end
                            mode_next = M_DRAIN;
                            state_next = is_last ? S_SETTLE : S_SETTLE2;
                        end else if (char_code == iee_pkg::CH_LPAREN) begin
                            if (stat.op_full) err_next = iee_pkg::ERR_OVERFLOW;
                            else begin
                                cmd.push_op = 1'b1;
                                cmd.op_code = iee_pkg::OP_LPAREN;
                            end
                            mode_next = M_DRAIN;
                            state_next = is_last ? S_SETTLE : S_SETTLE2;
                        end else if (char_code == iee_pkg::CH_RPAREN) begin
                            mode_next = M_CLOSE;
                        end else if (char_code == iee_pkg::CH_ADD) begin
                            mode_next = M_OPER; op_next = iee_pkg::OP_ADD;
                        end else if (char_code == iee_pkg::CH_SUB) begin
                            mode_next = M_OPER; op_next = iee_pkg::OP_SUB;
                        end else if (char_code == iee_pkg::CH_MUL) begin
                            mode_next = M_OPER; op_next = iee_pkg::OP_MUL;
                        end else if (char_code == iee_pkg::CH_DIV) begin
                            mode_next = M_OPER; op_next = iee_pkg::OP_DIV;
                        end else begin
                            err_next = iee_pkg::ERR_MALFORMED;
                            state_next = is_last ? S_SETTLE : S_IDLE;
                        end
                    end
                end
            end
            // let the top-of-stack read registers follow the counts
            S_SETTLE2: state_next = S_IDLE;
            S_SETTLE: begin
                state_next = S_CHECK;
                if (err_reg != iee_pkg::ERR_NONE) state_next = S_FINAL;
            end
            S_CHECK: begin
                if (err_reg != iee_pkg::ERR_NONE) state_next = last_reg ? S_FINAL : S_IDLE;
                else case (mode_reg)
                    M_OPER: begin
                        if (!stat.op_empty && stat.top_op != iee_pkg::OP_LPAREN &&
                            (top_hi || !hi_prec)) state_next = S_FETCH;
                        else begin
                            if (stat.op_full) err_next = iee_pkg::ERR_OVERFLOW;
                            else cmd.push_op = 1'b1;
                            mode_next = M_DRAIN;
                            state_next = last_reg ? S_SETTLE : S_SETTLE2;
                        end
                    end
                    M_CLOSE: begin
                        if (stat.op_empty) begin
                            err_next = iee_pkg::ERR_MALFORMED;
                            state_next = last_reg ? S_FINAL : S_IDLE;
                        end else if (stat.top_op == iee_pkg::OP_LPAREN) begin
                            cmd.pop_op = 1'b1;
                            mode_next = M_DRAIN;
                            state_next = last_reg ? S_SETTLE : S_SETTLE2;
                        end else state_next = S_FETCH;
                    end
                    default: begin
                        if (!last_reg) state_next = S_IDLE;
                        else if (stat.op_empty) state_next = S_FINAL;
                        else state_next = S_FETCH;
                    end
                endcase
            end
            S_FETCH: begin
                if (stat.val_lt2 || stat.top_op == iee_pkg::OP_LPAREN) begin
                    err_next = iee_pkg::ERR_MALFORMED;
                    state_next = last_reg ? S_FINAL : S_IDLE;
                end else begin
                    cmd.rd_req = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (stat.top_op == iee_pkg::OP_DIV && stat.div_zero) begin
                    err_next = iee_pkg::ERR_DIV0;
                    state_next = last_reg ? S_FINAL : S_IDLE;
                end else begin
                    cmd.alu_start = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT: if (stat.alu_done) state_next = S_COMMIT;
            S_COMMIT: begin
                cmd.alu_commit = 1'b1;
                state_next = S_SETTLE;
            end
            S_FINAL: begin
                if (err_reg == iee_pkg::ERR_NONE && !stat.val_one)
                    err_next = iee_pkg::ERR_MALFORMED;
                sel_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    cmd.clear = 1'b1;
                    err_next = iee_pkg::ERR_NONE;
                    sel_next = 1'b0;
                    state_next = S_SETTLE2;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            err_reg   <= iee_pkg::ERR_NONE;
            mode_reg  <= M_DRAIN;
            last_reg  <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            err_reg   <= err_next;
            mode_reg  <= mode_next;
            last_reg  <= last_next;
            sel_reg   <= sel_next;
        end
        op_reg <= op_next;
    end

    assign m_tvalid  = (state_reg == S_OUT);
    assign m_err     = err_reg;
    assign m_sel_val = sel_reg;
endmodule

[test/tb_infix_expression_evaluator_core.sv]
// testbench for infix_expression_evaluator_core: streams expressions one character
// per item and checks every result against an in-bench two-stack evaluator
// depends on iee_pkg and infix_expression_evaluator_core
`timescale 1ns / 100ps

module tb_infix_expression_evaluator_core;

    localparam int DEPTH = 32;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  err;
        logic [31:0] value;
    } eval_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    // evaluator state
    logic [31:0] val_stk [DEPTH];
    logic [2:0]  op_stk [DEPTH];
    int          val_cnt;
    int          op_cnt;
    logic [1:0]  err_flag;

    eval_result_t expected_results[$];
    int          failures;
    int          idle_cycles;
    int          out_stall_max;

    infix_expression_evaluator_core #(.STACK_DEPTH(DEPTH)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void raise_err(logic [1:0] e);
        if (err_flag == iee_pkg::ERR_NONE) err_flag = e;
    endfunction

    function automatic int prec_of(logic [2:0] o);
        if (o == iee_pkg::OP_ADD || o == iee_pkg::OP_SUB) return 1;
        if (o == iee_pkg::OP_MUL || o == iee_pkg::OP_DIV) return 2;
        return 0;
    endfunction

    function automatic void reduce_top();
        logic [31:0] a, b, r, ma, mb, q;
        logic [2:0]  o;
        if (op_cnt == 0 || val_cnt < 2) begin
            raise_err(iee_pkg::ERR_MALFORMED);
            return;
        end
        o = op_stk[op_cnt-1];
        if (o == iee_pkg::OP_LPAREN) begin
            raise_err(iee_pkg::ERR_MALFORMED);
            return;
        end
        a = val_stk[val_cnt-2];
        b = val_stk[val_cnt-1];
        case (o)
            iee_pkg::OP_ADD: r = a + b;
            iee_pkg::OP_SUB: r = a - b;
            iee_pkg::OP_MUL: r = a * b;
            default: begin
                if (b == 32'd0) begin
                    raise_err(iee_pkg::ERR_DIV0);
                    r = 32'd0;
                end else begin
                    ma = a[31] ? -a : a;
                    mb = b[31] ? -b : b;
                    q = ma / mb;
                    r = (a[31] != b[31]) ? -q : q;
                end
            end
        endcase
        if (err_flag != iee_pkg::ERR_NONE) return;
        op_cnt--;
        val_cnt--;
        val_stk[val_cnt-1] = r;
    endfunction

    function automatic void eval_char(logic [7:0] c);
        logic [2:0] o;
        if (c >= iee_pkg::CH_ZERO && c <= iee_pkg::CH_NINE) begin
            if (val_cnt >= DEPTH) raise_err(iee_pkg::ERR_OVERFLOW);
            else val_stk[val_cnt++] = 32'(c - iee_pkg::CH_ZERO);
            return;
        end
        if (c == iee_pkg::CH_LPAREN) begin
            if (op_cnt >= DEPTH) raise_err(iee_pkg::ERR_OVERFLOW);
            else op_stk[op_cnt++] = iee_pkg::OP_LPAREN;
            return;
        end
        if (c == iee_pkg::CH_RPAREN) begin
            while (err_flag == iee_pkg::ERR_NONE && op_cnt > 0 &&
                   op_stk[op_cnt-1] != iee_pkg::OP_LPAREN)
                reduce_top();
            if (err_flag != iee_pkg::ERR_NONE) return;
            if (op_cnt == 0) raise_err(iee_pkg::ERR_MALFORMED);
            else op_cnt--;
            return;
        end
        case (c)
            iee_pkg::CH_ADD: o = iee_pkg::OP_ADD;
            iee_pkg::CH_SUB: o = iee_pkg::OP_SUB;
            iee_pkg::CH_MUL: o = iee_pkg::OP_MUL;
            iee_pkg::CH_DIV: o = iee_pkg::OP_DIV;
            default: begin
                raise_err(iee_pkg::ERR_MALFORMED);
                return;
            end
        endcase
        while (err_flag == iee_pkg::ERR_NONE && op_cnt > 0 &&
               op_stk[op_cnt-1] != iee_pkg::OP_LPAREN &&
               prec_of(op_stk[op_cnt-1]) >= prec_of(o))
            reduce_top();
        if (err_flag == iee_pkg::ERR_NONE) begin
            if (op_cnt >= DEPTH) raise_err(iee_pkg::ERR_OVERFLOW);
            else op_stk[op_cnt++] = o;
        end
    endfunction

    // predicts one character; queues the result when it is the last one
    function automatic void predict_char(logic [7:0] c, logic last);
        eval_result_t res;
        if (err_flag == iee_pkg::ERR_NONE) eval_char(c);
        if (!last) return;
        while (err_flag == iee_pkg::ERR_NONE && op_cnt > 0) reduce_top();
        if (err_flag == iee_pkg::ERR_NONE && val_cnt != 1) raise_err(iee_pkg::ERR_MALFORMED);
        res.err = err_flag;
        res.value = (err_flag == iee_pkg::ERR_NONE) ? val_stk[0] : 32'd0;
        expected_results.push_back(res);
        val_cnt = 0;
        op_cnt = 0;
        err_flag = iee_pkg::ERR_NONE;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    task automatic send_char(logic [7:0] c, logic last);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_char(c, last);
        @(negedge aclk);
    endtask

    task automatic send_expr(string txt);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], i == txt.len() - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (expected_results.size() != 0);
    endtask

    // receiver: random stalls while out_stall_max is nonzero, compare each result item
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (out_stall_max == 0) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(99) < 8) ? 1'b0 :
                         ($urandom_range(99) < 60);
    end

    always @(posedge aclk) begin
        eval_result_t exp_r;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item: value %h error_code %0d",
                       m_tdata[31:0], m_tdata[33:32]);
                failures++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_tdata[31:0] !== exp_r.value) begin
                    $error("value: expected %h actual %h", exp_r.value, m_tdata[31:0]);
                    failures++;
                end
                if (m_tdata[33:32] !== exp_r.err) begin
                    $error("error_code: expected %0d actual %0d", exp_r.err, m_tdata[33:32]);
                    failures++;
                end
                if (m_tdata[39:34] !== 6'd0) begin
                    $error("fill: expected 0 actual %h", m_tdata[39:34]);
                    failures++;
                end
            end
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic test_directed();
        string deep;
        send_expr("7");
        send_expr("1+2*3-4/2");
        send_expr("(3)");
        send_expr("(1+2)*(9-3)/4");
        send_expr("8-3-2");
        send_expr("9/0");
        send_expr("-5");
        send_expr("2+)");
        send_expr("(2+3");
        send_expr("12");
        send_char(8'hff, 1'b1);
        send_char(8'h00, 1'b1);
        send_expr("1a+3");
        send_expr("7/2*0-9/4");
        // most negative over -1 wraps
        send_expr("(0-2*8*8*8*8*8*8*8*8*8*8)/(0-1)");
        send_expr("1/0+5");
        deep = "";
        for (int i = 0; i < DEPTH + 1; i++) deep = {deep, "1"};
        send_expr(deep);
        deep = "";
        for (int i = 0; i < DEPTH + 1; i++) deep = {deep, "("};
        send_expr({deep, "1"});
        send_expr("");
        send_expr("2*(");
        wait_drained();
    endtask

    function automatic string rand_expr(int d);
        int k;
        string s;
        k = $urandom_range(9);
        if (d == 0 || k < 3) begin
            s = " ";
            s[0] = 8'(iee_pkg::CH_ZERO + $urandom_range(9));
            return s;
        end
        if (k < 4) return {"(", rand_expr(d - 1), ")"};
        s = " ";
        case ($urandom_range(3))
            0: s[0] = iee_pkg::CH_ADD;
            1: s[0] = iee_pkg::CH_SUB;
            2: s[0] = iee_pkg::CH_MUL;
            default: s[0] = iee_pkg::CH_DIV;
        endcase
        return {rand_expr(d - 1), s, rand_expr(d - 1)};
    endfunction

    task automatic test_random(int target);
        int sent;
        string e;
        logic [7:0] c;
        sent = 0;
        while (sent < target) begin
            e = rand_expr($urandom_range(4, 1));
            if ($urandom_range(99) < 15) begin
                // corrupt one character with any byte
                c = 8'($urandom_range(255));
                e[$urandom_range(e.len() - 1)] = c;
            end
            for (int i = 0; i < e.len(); i++)
                send_char(e[i], i == e.len() - 1);
            sent += e.len();
            if ($urandom_range(99) < 3) begin
                out_stall_max = $urandom_range(1);
                wait_drained();
            end
        end
        wait_drained();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        failures = 0;
        val_cnt = 0;
        op_cnt = 0;
        err_flag = iee_pkg::ERR_NONE;
        out_stall_max = 1;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_random(1800);
        repeat (100) @(posedge aclk);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
